>>> rtl/core/pps_pkg.sv
// shared types, codes and helpers for the parallel printer byte sender
package pps_pkg;

  // opcodes of an input item
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_SEND  = 2'd1;
  localparam logic [1:0] OP_RESET = 2'd2;

  // sequencer phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_POLL   = 3'd1;
  localparam logic [2:0] PH_SETUP  = 3'd2;
  localparam logic [2:0] PH_STROBE = 3'd3;
  localparam logic [2:0] PH_RETRY  = 3'd4;
  localparam logic [2:0] PH_RESET  = 3'd5;

  // fault codes
  localparam logic [2:0] FAULT_NONE     = 3'd0;
  localparam logic [2:0] FAULT_TIMEOUT  = 3'd1;
  localparam logic [2:0] FAULT_NO_PAPER = 3'd2;
  localparam logic [2:0] FAULT_OFFLINE  = 3'd3;
  localparam logic [2:0] FAULT_PRINTER  = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_CHAR_TIMEOUT   = 3'd0;
  localparam logic [2:0] CFG_STROBE_WAIT    = 3'd1;
  localparam logic [2:0] CFG_RETRY_DELAY    = 3'd2;
  localparam logic [2:0] CFG_CAREFUL_MODE   = 3'd3;
  localparam logic [2:0] CFG_ABORT_ON_ERROR = 3'd4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // status pin positions
  localparam int ST_NOT_BUSY  = 7;
  localparam int ST_PAPER_OUT = 5;
  localparam int ST_SELECTED  = 4;
  localparam int ST_NO_ERROR  = 3;

  // careful-mode ready: not busy, paper present, selected, no error
  localparam logic [7:0] CAREFUL_MASK  = 8'hB8;
  localparam logic [7:0] CAREFUL_MATCH = 8'h98;

  // configuration reset values
  localparam logic [15:0] CHAR_TIMEOUT_RST = 16'd1000;
  localparam logic [15:0] STROBE_WAIT_RST  = 16'd1;
  localparam logic [15:0] RETRY_DELAY_RST  = 16'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic [7:0] status_pins;
  } pps_item_t;

  typedef struct packed {
    logic [7:0] data_lines;
    logic       strobe_line;
    logic       init_line;
    logic       select_line;
    logic       in_progress;
    logic       byte_done;
    logic [2:0] fault_code;
    logic       byte_dropped;
    logic       send_refused;
    logic [7:0] status_echo;
  } pps_result_t;

  typedef struct packed {
    logic [15:0] char_timeout;
    logic [15:0] strobe_wait;
    logic [15:0] retry_delay;
    logic        careful_mode;
    logic        abort_on_error;
  } pps_cfg_t;

  typedef struct packed {
    logic [2:0] phase;
    logic [7:0] held_byte;
    logic       strobe;
    logic       init;
    logic       select;
  } pps_ctrl_t;

  // timeout cause: paper out first, then offline, then error, else plain
  function automatic logic [2:0] classify(input logic [7:0] st);
    logic [2:0] code;
    if (st[ST_PAPER_OUT]) begin
      code = FAULT_NO_PAPER;
    end else if (!st[ST_SELECTED]) begin
      code = FAULT_OFFLINE;
    end else if (!st[ST_NO_ERROR]) begin
      code = FAULT_PRINTER;
    end else begin
      code = FAULT_TIMEOUT;
    end
    return code;
  endfunction

endpackage

>>> rtl/core/pps_if.sv
// channel interfaces: input items, result items, configuration writes

interface pps_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] data_byte;
  logic [7:0] status_pins;

  modport source (output valid, output opcode, output data_byte, output status_pins,
                  input ready);
  modport sink (input valid, input opcode, input data_byte, input status_pins,
                output ready);
endinterface

interface pps_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_lines;
  logic       strobe_line;
  logic       init_line;
  logic       select_line;
  logic       in_progress;
  logic       byte_done;
  logic [2:0] fault_code;
  logic       byte_dropped;
  logic       send_refused;
  logic [7:0] status_echo;

  modport source (output valid, output data_lines, output strobe_line, output init_line,
                  output select_line, output in_progress, output byte_done,
                  output fault_code, output byte_dropped, output send_refused,
                  output status_echo, input ready);
  modport sink (input valid, input data_lines, input strobe_line, input init_line,
                input select_line, input in_progress, input byte_done,
                input fault_code, input byte_dropped, input send_refused,
                input status_echo, output ready);
endinterface

interface pps_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pps_pkg::CFG_INDEX_W-1:0] index;
  logic [pps_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/pps_cfg_regs.sv
// configuration register file, written through the config channel
module pps_cfg_regs (
  input  logic             clk,
  input  logic             rst,
  pps_cfg_if.sink          cfg,
  output pps_pkg::pps_cfg_t cfg_q
);

  // writes are always taken
  assign cfg.ready = 1'b1;

  // register decode
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.char_timeout   <= pps_pkg::CHAR_TIMEOUT_RST;
      cfg_q.strobe_wait    <= pps_pkg::STROBE_WAIT_RST;
      cfg_q.retry_delay    <= pps_pkg::RETRY_DELAY_RST;
      cfg_q.careful_mode   <= 1'b0;
      cfg_q.abort_on_error <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        pps_pkg::CFG_CHAR_TIMEOUT:   cfg_q.char_timeout   <= cfg.data;
        pps_pkg::CFG_STROBE_WAIT:    cfg_q.strobe_wait    <= cfg.data;
        pps_pkg::CFG_RETRY_DELAY:    cfg_q.retry_delay    <= cfg.data;
        pps_pkg::CFG_CAREFUL_MODE:   cfg_q.careful_mode   <= cfg.data[0];
        pps_pkg::CFG_ABORT_ON_ERROR: cfg_q.abort_on_error <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/core/pps_step.sv
// next-state and result logic for one item of the port sequencer
module pps_step #(
  parameter int CW                = 16,
  parameter int RESET_PULSE_TICKS = 50
) (
  input  pps_pkg::pps_item_t   item,
  input  pps_pkg::pps_cfg_t    cfg_q,
  input  pps_pkg::pps_ctrl_t   ctrl,
  input  logic [CW-1:0]        poll_count,
  input  logic [CW-1:0]        wait_count,
  output pps_pkg::pps_ctrl_t   ctrl_next,
  output logic [CW-1:0]        poll_count_next,
  output logic [CW-1:0]        wait_count_next,
  output pps_pkg::pps_result_t result
);

  localparam logic [63:0] CMAX64 = (64'd1 << CW) - 64'd1;

  // saturate a loaded value to the counter width
  function automatic logic [CW-1:0] sat(input logic [31:0] v);
    logic [CW-1:0] r;
    if (64'(v) > CMAX64) begin
      r = '1;
    end else begin
      r = CW'(v);
    end
    return r;
  endfunction

  logic          done;
  logic [2:0]    fault;
  logic          dropped;
  logic          refused;
  logic          prn_ready;
  logic [CW-1:0] poll_inc;
  logic [CW-1:0] wait_dec;
  logic [CW-1:0] limit;
  logic [15:0]   timeout_eff;

  // shared count helpers
  assign poll_inc    = poll_count + CW'(poll_count != '1);
  assign wait_dec    = wait_count - CW'(wait_count != '0);
  assign timeout_eff = (cfg_q.char_timeout == 16'd0) ? 16'd1 : cfg_q.char_timeout;
  assign limit       = sat(32'(timeout_eff));
  assign prn_ready   = cfg_q.careful_mode
                     ? ((item.status_pins & pps_pkg::CAREFUL_MASK) == pps_pkg::CAREFUL_MATCH)
                     : item.status_pins[pps_pkg::ST_NOT_BUSY];

  // command decode and phase sequencer
  always_comb begin
    ctrl_next       = ctrl;
    poll_count_next = poll_count;
    wait_count_next = wait_count;
    done            = 1'b0;
    fault           = pps_pkg::FAULT_NONE;
    dropped         = 1'b0;
    refused         = 1'b0;
    unique case (item.opcode)
      pps_pkg::OP_SEND: begin
        if (ctrl.phase != pps_pkg::PH_IDLE) begin
          refused = 1'b1;
        end else begin
          ctrl_next.held_byte = item.data_byte;
          ctrl_next.phase     = pps_pkg::PH_POLL;
          poll_count_next     = '0;
        end
      end
      pps_pkg::OP_RESET: begin
        if (ctrl.phase != pps_pkg::PH_IDLE) begin
          refused = 1'b1;
        end else begin
          ctrl_next.strobe = 1'b0;
          ctrl_next.init   = 1'b0;
          ctrl_next.select = 1'b0;
          ctrl_next.phase  = pps_pkg::PH_RESET;
          wait_count_next  = sat(32'(RESET_PULSE_TICKS));
        end
      end
      pps_pkg::OP_TICK: begin
        unique case (ctrl.phase)
          pps_pkg::PH_POLL: begin
            poll_count_next = poll_inc;
            if (prn_ready) begin
              if (cfg_q.strobe_wait == 16'd0) begin
                ctrl_next.phase = pps_pkg::PH_STROBE;
                wait_count_next = '0;
              end else begin
                ctrl_next.phase = pps_pkg::PH_SETUP;
                wait_count_next = sat(32'(cfg_q.strobe_wait));
              end
            end else if (poll_inc >= limit) begin
              fault = pps_pkg::classify(item.status_pins);
              if (fault != pps_pkg::FAULT_TIMEOUT && cfg_q.abort_on_error) begin
                dropped         = 1'b1;
                ctrl_next.phase = pps_pkg::PH_IDLE;
              end else if (cfg_q.retry_delay == 16'd0) begin
                poll_count_next = '0;
              end else begin
                ctrl_next.phase = pps_pkg::PH_RETRY;
                wait_count_next = sat(32'(cfg_q.retry_delay));
              end
            end
          end
          pps_pkg::PH_SETUP: begin
            if (wait_dec == '0) begin
              ctrl_next.phase = pps_pkg::PH_STROBE;
              wait_count_next = sat(32'(cfg_q.strobe_wait));
            end else begin
              wait_count_next = wait_dec;
            end
          end
          pps_pkg::PH_STROBE: begin
            if (wait_count != '0) begin
              wait_count_next  = wait_dec;
              ctrl_next.strobe = 1'b1;
            end else begin
              ctrl_next.strobe = 1'b0;
              ctrl_next.phase  = pps_pkg::PH_IDLE;
              done             = 1'b1;
            end
          end
          pps_pkg::PH_RETRY: begin
            wait_count_next = wait_dec;
            if (wait_dec == '0) begin
              ctrl_next.phase = pps_pkg::PH_POLL;
              poll_count_next = '0;
            end
          end
          pps_pkg::PH_RESET: begin
            wait_count_next = wait_dec;
            if (wait_dec == '0) begin
              ctrl_next.init   = 1'b1;
              ctrl_next.select = 1'b1;
              ctrl_next.phase  = pps_pkg::PH_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // result fields, taken after this item's update
  always_comb begin
    result.data_lines   = (ctrl_next.phase == pps_pkg::PH_SETUP ||
                           ctrl_next.phase == pps_pkg::PH_STROBE || done)
                        ? ctrl_next.held_byte : 8'd0;
    result.strobe_line  = ctrl_next.strobe;
    result.init_line    = ctrl_next.init;
    result.select_line  = ctrl_next.select;
    result.in_progress  = (ctrl_next.phase != pps_pkg::PH_IDLE);
    result.byte_done    = done;
    result.fault_code   = fault;
    result.byte_dropped = dropped;
    result.send_refused = refused;
    result.status_echo  = item.status_pins;
  end

endmodule

>>> rtl/core/parallel_printer_byte_sender_unit.sv
// top level: host-side parallel printer port sequencer
// path of an accepted item to its result: input register, then result register
// throughput: one item per cycle while results are taken; the sequencer state updates
// once per item; a result waiting in the output register holds the input register;
// input takes one more item only while that register is empty or passes its item on
// reset (rst, synchronous): phase idle, counts and held byte zero, init and select high,
// strobe low, config registers to defaults, both pipeline registers empty
module parallel_printer_byte_sender_unit #(
  parameter int COUNT_WIDTH       = 16,
  parameter int RESET_PULSE_TICKS = 50
) (
  input logic          clk,
  input logic          rst,
  pps_item_if.sink     items,
  pps_result_if.source results,
  pps_cfg_if.sink      cfg
);

  pps_pkg::pps_cfg_t    cfg_q;
  pps_pkg::pps_item_t   s1_item;
  logic                 s1_valid;
  logic                 r_valid;
  pps_pkg::pps_result_t r_result;
  pps_pkg::pps_result_t step_result;
  pps_pkg::pps_ctrl_t   ctrl;
  pps_pkg::pps_ctrl_t   ctrl_next;
  logic [COUNT_WIDTH-1:0] poll_count;
  logic [COUNT_WIDTH-1:0] poll_count_next;
  logic [COUNT_WIDTH-1:0] wait_count;
  logic [COUNT_WIDTH-1:0] wait_count_next;
  logic                 out_free;
  logic                 s1_adv;

  pps_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .cfg_q (cfg_q)
  );

  pps_step #(
    .CW                (COUNT_WIDTH),
    .RESET_PULSE_TICKS (RESET_PULSE_TICKS)
  ) u_step (
    .item            (s1_item),
    .cfg_q           (cfg_q),
    .ctrl            (ctrl),
    .poll_count      (poll_count),
    .wait_count      (wait_count),
    .ctrl_next       (ctrl_next),
    .poll_count_next (poll_count_next),
    .wait_count_next (wait_count_next),
    .result          (step_result)
  );

  // flow control
  assign out_free    = !r_valid || results.ready;
  assign s1_adv      = s1_valid && out_free;
  assign items.ready = !s1_valid || s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.ready) begin
      s1_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      s1_item.opcode      <= items.opcode;
      s1_item.data_byte   <= items.data_byte;
      s1_item.status_pins <= items.status_pins;
    end
  end

  // sequencer state, advanced once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.phase     <= pps_pkg::PH_IDLE;
      ctrl.held_byte <= 8'd0;
      ctrl.strobe    <= 1'b0;
      ctrl.init      <= 1'b1;
      ctrl.select    <= 1'b1;
      poll_count     <= '0;
      wait_count     <= '0;
    end else if (s1_adv) begin
      ctrl       <= ctrl_next;
      poll_count <= poll_count_next;
      wait_count <= wait_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (out_free) begin
      r_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      r_result <= step_result;
    end
  end

  // result channel
  assign results.valid        = r_valid;
  assign results.data_lines   = r_result.data_lines;
  assign results.strobe_line  = r_result.strobe_line;
  assign results.init_line    = r_result.init_line;
  assign results.select_line  = r_result.select_line;
  assign results.in_progress  = r_result.in_progress;
  assign results.byte_done    = r_result.byte_done;
  assign results.fault_code   = r_result.fault_code;
  assign results.byte_dropped = r_result.byte_dropped;
  assign results.send_refused = r_result.send_refused;
  assign results.status_echo  = r_result.status_echo;

  // strobe is only ever high during the strobe phase
  a_strobe_phase: assert property (@(posedge clk) disable iff (rst)
    ctrl.strobe |-> ctrl.phase == pps_pkg::PH_STROBE)
    else $error("strobe high outside strobe phase");

  // init pulse only during the printer reset phase
  a_init_phase: assert property (@(posedge clk) disable iff (rst)
    !ctrl.init |-> ctrl.phase == pps_pkg::PH_RESET)
    else $error("init low outside reset phase");

  // state moves only when an item passes to the result register
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    (!rst && !s1_adv) |=> ($stable(ctrl) && $stable(poll_count) && $stable(wait_count)))
    else $error("sequencer state changed without an item");

  // a finished byte always shows the strobe released
  a_done_strobe: assert property (@(posedge clk) disable iff (rst)
    (r_valid && r_result.byte_done) |-> !r_result.strobe_line && !r_result.in_progress)
    else $error("byte done with strobe high or still busy");

endmodule
